[sv/tpsd_pkg.sv]
package tpsd_pkg;

  localparam int DataW = 8;
  localparam int ResW  = 40;

  // pixel mode codes
  localparam logic [2:0] MODE_RAW24 = 3'd0;
  localparam logic [2:0] MODE_RAW32 = 3'd1;
  localparam logic [2:0] MODE_RAW16 = 3'd2;
  localparam logic [2:0] MODE_RLE24 = 3'd3;
  localparam logic [2:0] MODE_RLE32 = 3'd4;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [7:0] RLE_REPEAT_BIAS = 8'd127;

  typedef struct packed {
    logic        clear;       // restart the stream at this edge
    logic [31:0] total_next;  // pixel total that takes effect with clear
    logic [2:0]  mode;
  } cfg_t;

  typedef struct packed {
    logic            last;
    logic [ResW-1:0] data;    // red, green, blue, alpha, run_length from bit 0 up
  } res_t;

endpackage

[sv/tpsd_cfg.sv]
module tpsd_cfg
  import tpsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output cfg_t        cfg
);

  logic [2:0]  pixel_mode;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic        wr;
  logic [1:0]  idx;
  logic [15:0] mul_a;
  logic [15:0] mul_b;

  assign wr  = psel & penable & pwrite;
  assign idx = paddr[3:2];

  // new total from the value being written and the register it does not touch
  assign mul_a = (idx == REG_WIDTH)  ? pwdata[15:0] : image_width;
  assign mul_b = (idx == REG_HEIGHT) ? pwdata[15:0] : image_height;

  always_comb begin
    cfg.mode       = pixel_mode;
    cfg.total_next = {16'd0, mul_a} * {16'd0, mul_b};
    case (idx)
      REG_MODE, REG_WIDTH, REG_HEIGHT: cfg.clear = wr;
      default:                         cfg.clear = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_mode   <= MODE_RAW24;
      image_width  <= '0;
      image_height <= '0;
    end else if (wr) begin
      case (idx)
        REG_MODE:   pixel_mode   <= pwdata[2:0];
        REG_WIDTH:  image_width  <= pwdata[15:0];
        REG_HEIGHT: image_height <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:   prdata = {29'd0, pixel_mode};
      REG_WIDTH:  prdata = {16'd0, image_width};
      REG_HEIGHT: prdata = {16'd0, image_height};
      default:    prdata = '0;
    endcase
  end

endmodule

[sv/tpsd_decode.sv]
module tpsd_decode
  import tpsd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             take,
  input  logic [DataW-1:0] data_byte,
  output logic             res_valid,
  output res_t             res
);

  logic [1:0]  byte_phase;
  logic [23:0] color_bytes;
  logic [7:0]  packet_remaining;
  logic        packet_is_repeat;
  logic [31:0] pixels_left;

  logic [1:0]  byte_phase_next;
  logic [23:0] color_bytes_next;
  logic [7:0]  packet_remaining_next;
  logic        packet_is_repeat_next;
  logic [31:0] pixels_left_next;

  logic        active;
  logic        rle;
  logic [1:0]  last_phase;
  logic [15:0] word16;
  logic [7:0]  red, green, blue, alpha, run;
  logic        left_short;

  always_comb begin
    rle        = (cfg.mode == MODE_RLE24) || (cfg.mode == MODE_RLE32);
    active     = (cfg.mode <= MODE_RLE32) && (pixels_left != '0);
    case (cfg.mode)
      MODE_RAW16:             last_phase = 2'd1;
      MODE_RAW32, MODE_RLE32: last_phase = 2'd3;
      default:                last_phase = 2'd2;
    endcase

    word16 = {data_byte, color_bytes[7:0]};
    case (last_phase)
      2'd1: begin
        blue  = {word16[4:0], 3'b000};
        green = {word16[9:5], 3'b000};
        red   = {word16[14:10], 3'b000};
        alpha = '0;
      end
      2'd2: begin
        blue  = color_bytes[7:0];
        green = color_bytes[15:8];
        red   = data_byte;
        alpha = '0;
      end
      default: begin
        blue  = color_bytes[7:0];
        green = color_bytes[15:8];
        red   = color_bytes[23:16];
        alpha = data_byte;
      end
    endcase

    // clip a repeat run at the pixels still owed
    left_short = (pixels_left[31:8] == '0) && (pixels_left[7:0] < packet_remaining);
    if (rle && packet_is_repeat) begin
      run = left_short ? pixels_left[7:0] : packet_remaining;
    end else begin
      run = 8'd1;
    end

    byte_phase_next       = byte_phase;
    color_bytes_next      = color_bytes;
    packet_remaining_next = packet_remaining;
    packet_is_repeat_next = packet_is_repeat;
    pixels_left_next      = pixels_left;
    res_valid             = 1'b0;

    if (take && active) begin
      if (rle && packet_remaining == '0) begin
        // packet header
        packet_is_repeat_next = data_byte[7];
        packet_remaining_next = data_byte[7] ? data_byte - RLE_REPEAT_BIAS : data_byte + 8'd1;
        byte_phase_next       = '0;
        color_bytes_next      = '0;
      end else if (byte_phase != last_phase) begin
        case (byte_phase)
          2'd0:    color_bytes_next[7:0]   = data_byte;
          2'd1:    color_bytes_next[15:8]  = data_byte;
          default: color_bytes_next[23:16] = data_byte;
        endcase
        byte_phase_next = byte_phase + 2'd1;
      end else begin
        byte_phase_next  = '0;
        color_bytes_next = '0;
        pixels_left_next = pixels_left - {24'd0, run};
        res_valid        = 1'b1;
        if (rle) begin
          packet_remaining_next = packet_is_repeat ? 8'd0 : packet_remaining - 8'd1;
        end
      end
    end

    res.data = {run, alpha, blue, green, red};
    res.last = (pixels_left_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase       <= '0;
      color_bytes      <= '0;
      packet_remaining <= '0;
      packet_is_repeat <= 1'b0;
      pixels_left      <= '0;
    end else if (cfg.clear) begin
      byte_phase       <= '0;
      color_bytes      <= '0;
      packet_remaining <= '0;
      packet_is_repeat <= 1'b0;
      pixels_left      <= cfg.total_next;
    end else begin
      byte_phase       <= byte_phase_next;
      color_bytes      <= color_bytes_next;
      packet_remaining <= packet_remaining_next;
      packet_is_repeat <= packet_is_repeat_next;
      pixels_left      <= pixels_left_next;
    end
  end

endmodule

[sv/tpsd_skid.sv]
module tpsd_skid
  import tpsd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_data,
  output logic room,
  input  logic pop,
  output logic head_valid,
  output res_t head
);

  logic [1:0] count;
  res_t       spare;

  assign room       = (count != 2'd2);
  assign head_valid = (count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count == 2'd0) head  <= push_data;
        else               spare <= push_data;
      end
      2'b01: head <= spare;
      2'b11: begin
        // spare advances and push refills it; a lone head takes push
        if (count == 2'd1) begin
          head <= push_data;
        end else begin
          head  <= spare;
          spare <= push_data;
        end
      end
      default: ;
    endcase
  end

endmodule

[sv/tga_pixel_stream_decoder_core.sv]
// Channel   Direction  Handshake           Payload
// s_        in         s_tvalid/s_tready   s_tdata: data_byte
// m_        out        m_tvalid/m_tready   m_tdata: red, green, blue, alpha, run_length;
//                                          m_tlast: image_done
// apb       in         psel/penable        pixel_mode @0x0, image_width @0x4, image_height @0x8
//
// One byte is taken per cycle while s_tready is high; a completed pixel is registered into the output buffer.
// Header bytes and partial pixel bytes produce no transfer.
// A two-entry output buffer absorbs results while m_tready is low; s_tready falls only when both entries are full.
// rst is synchronous; any register write restarts the stream for the new image.
module tga_pixel_stream_decoder_core
  import tpsd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [DataW-1:0] s_tdata,   // [7:0] data_byte
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [ResW-1:0]  m_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                      // [31:24] alpha, [39:32] run_length
  output logic             m_tlast,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t cfg;
  logic take;
  logic res_valid;
  res_t res;
  res_t head;

  assign pready = 1'b1;
  assign take   = s_tvalid & s_tready;

  tpsd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  tpsd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .take      (take),
    .data_byte (s_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  tpsd_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_data  (res),
    .room       (s_tready),
    .pop        (m_tvalid & m_tready),
    .head_valid (m_tvalid),
    .head       (head)
  );

  assign m_tdata = head.data;
  assign m_tlast = head.last;

`ifndef SYNTHESIS
  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[39:32] != 8'd0))
    else $error("zero run length on output");

  a_long_run_rle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[39:32] > 8'd1) |-> (cfg.mode == MODE_RLE24 || cfg.mode == MODE_RLE32))
    else $error("run longer than one pixel outside RLE mode");

  a_full_has_head: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no pending result");
`endif

endmodule
